// ----- rtl/fraction_sum_reducer_macros.svh -----
// Assertion macros for the fraction sum reducer
`ifndef FRACTION_SUM_REDUCER_MACROS_SVH
`define FRACTION_SUM_REDUCER_MACROS_SVH
`ifndef SYNTH
`define FSR_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("label");
`define FSR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("label");
`else
`define FSR_ASSERT_IMPL(label, clk, rst, prop)
`define FSR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- rtl/fsr_pkg.sv -----
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared types and constants of the fraction sum reducer.
// ----------------------------------------------------------------------------
package fsr_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH = 32;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_ZERO     = 2'd2;

   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic mul_c;
      logic add_num;
      logic gcd_init;
      logic div_start;
      logic [1:0] div_sel;
      logic gcd_step;
      logic den_div_done;
      logic num_div_done;
      logic zero_mark;
      logic fix_sign;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic gcd_b_zero;
      logic gcd_a_zero;
      logic den_zero;
      logic last;
   } stat_type;

   localparam logic [1:0] DSEL_GCD = 2'd0;
   localparam logic [1:0] DSEL_DEN = 2'd1;
   localparam logic [1:0] DSEL_NUM = 2'd2;
endpackage

// ----- rtl/fraction_sum_reducer.sv -----
// ----------------------------------------------------------------------------
// fraction_sum_reducer
// Running sum of signed fractions, reduced by gcd, emitted on the last term.
// ----------------------------------------------------------------------------
// Each request runs through load, multiply, add and checks, one divider pass
// per Euclid step, and two more such passes for the reduction (skipped when
// the gcd is zero), all on one shared bit-serial divider; a last term then
// waits in the output register until taken. Status: 0 ok, 1 overflow seen,
// 2 zero gcd or denominator seen.
`include "fraction_sum_reducer_macros.svh"
module fraction_sum_reducer import fsr_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // numerator, denominator
   input  logic        req_tlast,  // last_term
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // sum_numerator, sum_denominator, status, zero fill
);
   cmd_type  cmd;
   stat_type stat;
   logic [FIELD_WIDTH-1:0] out_num, out_den;
   logic [1:0] out_status;

   fsr_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   fsr_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_num(req_tdata[31:0]), .in_den(req_tdata[63:32]), .in_last(req_tlast),
      .out_num(out_num), .out_den(out_den), .out_status(out_status)
   );

   assign rsp_tdata = {6'd0, out_status, out_den, out_num};

   `FSR_ASSERT_IMPL(a_no_accept_while_out, clock, reset, !(req_tready && rsp_tvalid))
   `FSR_ASSERT_NEXT(a_out_clears, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)
   `FSR_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

// ----- rtl/fsr_divider.sv -----
// ----------------------------------------------------------------------------
// fsr_divider
// Radix-2 restoring magnitude divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsr_divider import fsr_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);
   localparam int CW = $clog2(DATA_WIDTH + 1);
   logic [DATA_WIDTH-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DATA_WIDTH:0] trial, shifted;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      shifted = {r_ff, q_ff[DATA_WIDTH-1]};
      trial = shifted - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(DATA_WIDTH); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            r_in = trial[DATA_WIDTH-1:0];
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            r_in = shifted[DATA_WIDTH-1:0];
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = busy_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// ----- rtl/fsr_datapath.sv -----
// ----------------------------------------------------------------------------
// fsr_datapath
// Accumulator registers, shared multiplier, adder, Euclid and division logic.
// ----------------------------------------------------------------------------
module fsr_datapath import fsr_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [FIELD_WIDTH-1:0] in_num,
   input  logic [FIELD_WIDTH-1:0] in_den,
   input  logic                   in_last,
   output logic [FIELD_WIDTH-1:0] out_num,
   output logic [FIELD_WIDTH-1:0] out_den,
   output logic [1:0]             out_status
);
   localparam int W = DATA_WIDTH;
   logic [W-1:0] num_ff, num_in, den_ff, den_in;
   logic [W-1:0] acc_num_ff, acc_num_in, acc_den_ff, acc_den_in;
   logic [W-1:0] term_ff, term_in, ga_ff, ga_in, gb_ff, gb_in;
   logic [1:0] err_ff, err_in;
   logic last_ff, last_in;
   logic [W-1:0] mx, my, mag_x, mag_y, mp_lo;
   logic [2*W-1:0] mp;
   logic m_neg, m_ovf;
   logic [W-1:0] sum;
   logic [W-1:0] dv_a, dv_b, dv_q, dv_r, q_signed, r_signed, neg_num, neg_den;
   logic dv_busy, q_neg, q_ovf;
   logic [W-1:0] min_val;

   function automatic logic [W-1:0] absv(input logic [W-1:0] v);
      absv = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [W-1:0] sext(input logic [FIELD_WIDTH-1:0] v);
      logic [W+FIELD_WIDTH-1:0] t;
      t = {{W{v[FIELD_WIDTH-1]}}, v};
      sext = t[W-1:0];
   endfunction

   assign min_val = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      mx = num_ff; my = acc_den_ff;
      if (cmd.mul_b) begin mx = acc_den_ff; my = den_ff; end
      if (cmd.mul_c) begin mx = acc_num_ff; my = den_ff; end
   end
   assign mag_x = absv(mx);
   assign mag_y = absv(my);
   assign mp = {{W{1'b0}}, mag_x} * {{W{1'b0}}, mag_y};
   assign m_neg = (mx[W-1] != my[W-1]) && (mp != '0);
   assign mp_lo = m_neg ? (~mp[W-1:0] + 1'b1) : mp[W-1:0];
   assign m_ovf = (mp[2*W-1:W] != '0) ||
                  (mp[W-1] && !(m_neg && mp[W-2:0] == '0));

   assign sum = acc_num_ff + term_ff;

   always_comb begin
      dv_a = ga_ff; dv_b = gb_ff;
      case (cmd.div_sel)
         DSEL_GCD: begin dv_a = ga_ff; dv_b = gb_ff; end
         DSEL_DEN: begin dv_a = acc_den_ff; dv_b = ga_ff; end
         DSEL_NUM: begin dv_a = acc_num_ff; dv_b = ga_ff; end
         default:  begin dv_a = ga_ff; dv_b = gb_ff; end
      endcase
   end

   fsr_divider #(.DATA_WIDTH(W)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(absv(dv_a)), .divisor(absv(dv_b)),
      .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
   );

   assign r_signed = dv_a[W-1] ? (~dv_r + 1'b1) : dv_r;
   assign q_neg = (dv_a[W-1] != dv_b[W-1]) && (dv_q != '0);
   assign q_signed = q_neg ? (~dv_q + 1'b1) : dv_q;
   assign q_ovf = dv_q[W-1] && !(q_neg && dv_q[W-2:0] == '0);
   assign neg_num = ~acc_num_ff + 1'b1;
   assign neg_den = ~acc_den_ff + 1'b1;

   always_comb begin
      num_in = num_ff; den_in = den_ff; last_in = last_ff;
      acc_num_in = acc_num_ff; acc_den_in = acc_den_ff; term_in = term_ff;
      ga_in = ga_ff; gb_in = gb_ff; err_in = err_ff;
      if (cmd.load) begin
         num_in = sext(in_num); den_in = sext(in_den); last_in = in_last;
      end
      if (cmd.mul_a) begin term_in = mp_lo; if (m_ovf) err_in[0] = 1'b1; end
      if (cmd.mul_b) begin acc_den_in = mp_lo; if (m_ovf) err_in[0] = 1'b1; end
      if (cmd.mul_c) begin acc_num_in = mp_lo; if (m_ovf) err_in[0] = 1'b1; end
      if (cmd.add_num) begin
         acc_num_in = sum;
         if (acc_num_ff[W-1] == term_ff[W-1] && sum[W-1] != acc_num_ff[W-1])
            err_in[0] = 1'b1;
      end
      if (cmd.gcd_init) begin ga_in = acc_num_ff; gb_in = acc_den_ff; end
      if (cmd.gcd_step) begin ga_in = gb_ff; gb_in = r_signed; end
      if (cmd.den_div_done) begin
         acc_den_in = q_signed; if (q_ovf) err_in[0] = 1'b1;
      end
      if (cmd.num_div_done) begin
         acc_num_in = q_signed; if (q_ovf) err_in[0] = 1'b1;
      end
      if (cmd.zero_mark) err_in[1] = 1'b1;
      if (cmd.fix_sign && acc_den_ff[W-1]) begin
         if (acc_den_ff == min_val || acc_num_ff == min_val) err_in[0] = 1'b1;
         acc_num_in = neg_num; acc_den_in = neg_den;
      end
      if (cmd.clear) begin
         acc_num_in = '0; acc_den_in = {{(W-1){1'b0}}, 1'b1}; err_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= {{(W-1){1'b0}}, 1'b1};
         err_ff <= '0;
      end else begin
         acc_num_ff <= acc_num_in; acc_den_ff <= acc_den_in; err_ff <= err_in;
      end
      num_ff <= num_in; den_ff <= den_in; last_ff <= last_in;
      term_ff <= term_in; ga_ff <= ga_in; gb_ff <= gb_in;
   end

   assign stat.div_busy = dv_busy;
   assign stat.gcd_b_zero = (gb_ff == '0);
   assign stat.gcd_a_zero = (ga_ff == '0);
   assign stat.den_zero = (acc_den_ff == '0);
   assign stat.last = last_ff;

   assign out_num = FIELD_WIDTH'(signed'(acc_num_ff));
   assign out_den = FIELD_WIDTH'(signed'(acc_den_ff));
   assign out_status = err_ff[1] ? STATUS_ZERO : (err_ff[0] ? STATUS_OVERFLOW : STATUS_OK);
endmodule

// ----- rtl/fsr_control.sv -----
// ----------------------------------------------------------------------------
// fsr_control
// Sequencer for multiply, add, Euclid loop, reduction and result hand-off.
// ----------------------------------------------------------------------------
module fsr_control import fsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);
   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_MULA  = 14'b00000000000010,
      S_MULB  = 14'b00000000000100,
      S_MULC  = 14'b00000000001000,
      S_ADD   = 14'b00000000010000,
      S_GINIT = 14'b00000000100000,
      S_GTEST = 14'b00000001000000,
      S_GWAIT = 14'b00000010000000,
      S_DSTRT = 14'b00000100000000,
      S_DWAIT = 14'b00001000000000,
      S_NSTRT = 14'b00010000000000,
      S_NWAIT = 14'b00100000000000,
      S_CHECK = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic first_ff, first_in;

   always_comb begin
      state_in = state_ff; first_in = 1'b0;
      cmd = '0;
      req_ready = 1'b0; rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin cmd.load = 1'b1; state_in = S_MULA; end
         end
         S_MULA: begin cmd.mul_a = 1'b1; state_in = S_MULB; end
         S_MULB: begin cmd.mul_b = 1'b1; state_in = S_MULC; end
         S_MULC: begin cmd.mul_c = 1'b1; state_in = S_ADD; end
         S_ADD: begin cmd.add_num = 1'b1; state_in = S_GINIT; end
         S_GINIT: begin cmd.gcd_init = 1'b1; state_in = S_GTEST; end
         S_GTEST: begin
            if (!stat.gcd_b_zero) begin
               cmd.div_start = 1'b1; cmd.div_sel = DSEL_GCD;
               first_in = 1'b1; state_in = S_GWAIT;
            end else if (stat.gcd_a_zero) begin
               cmd.zero_mark = 1'b1; state_in = S_CHECK;
            end else begin
               state_in = S_DSTRT;
            end
         end
         S_GWAIT: begin
            cmd.div_sel = DSEL_GCD;
            if (!stat.div_busy && !first_ff) begin
               cmd.gcd_step = 1'b1; state_in = S_GTEST;
            end
         end
         S_DSTRT: begin
            cmd.div_start = 1'b1; cmd.div_sel = DSEL_DEN;
            first_in = 1'b1; state_in = S_DWAIT;
         end
         S_DWAIT: begin
            cmd.div_sel = DSEL_DEN;
            if (!stat.div_busy && !first_ff) begin
               cmd.den_div_done = 1'b1; state_in = S_NSTRT;
            end
         end
         S_NSTRT: begin
            cmd.div_start = 1'b1; cmd.div_sel = DSEL_NUM;
            first_in = 1'b1; state_in = S_NWAIT;
         end
         S_NWAIT: begin
            cmd.div_sel = DSEL_NUM;
            if (!stat.div_busy && !first_ff) begin
               cmd.num_div_done = 1'b1; state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.den_zero) cmd.zero_mark = 1'b1;
            if (stat.last) begin cmd.fix_sign = 1'b1; state_in = S_OUT; end
            else state_in = S_IDLE;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin cmd.clear = 1'b1; state_in = S_IDLE; end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; first_ff <= first_in;
      end
   end
endmodule
